// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// The expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ===== rtl/core/bpe_pkg.sv =====
// Shared constants, codes and types of the polynomial surface evaluator.
package bpe_pkg;

    localparam int MAX_VOLUME_ORDER      = 8;
    localparam int MAX_TEMPERATURE_ORDER = 8;
    localparam int TABLE_SIZE = MAX_VOLUME_ORDER * MAX_TEMPERATURE_ORDER;

    // Field widths.
    localparam int IDX_W  = 6;
    localparam int COEF_W = 48;
    localparam int IN_W   = 32;
    localparam int OUT_W  = 64;
    localparam int ORD_W  = 4;

    // Index and counter widths.
    localparam int VI_W   = (MAX_VOLUME_ORDER > 1) ? $clog2(MAX_VOLUME_ORDER) : 1;
    localparam int TI_W   = (MAX_TEMPERATURE_ORDER > 1) ? $clog2(MAX_TEMPERATURE_ORDER) : 1;
    localparam int ADDR_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CNT_W  = 5;

    // Arithmetic widths.
    localparam int FRAC     = 30;
    localparam int OPND_W   = 64;
    localparam int PROD_W   = 2 * OPND_W;
    localparam int HALF_W   = OPND_W / 2;
    localparam int ACC_W    = 80;
    localparam int WEIGHT_W = 8;

    // Command queue between front and back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_ORDER      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMPERATURE_ORDER = 4'd1;
    localparam logic [ORD_W-1:0]     ORDER_RESET           = 4'd8;

    // Command codes.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    typedef struct packed {
        logic                     command;
        logic [IDX_W-1:0]         coef_index;
        logic signed [COEF_W-1:0] coef_value;
        logic signed [IN_W-1:0]   volume;
        logic signed [IN_W-1:0]   temperature;
    } t_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] energy;
        logic signed [OUT_W-1:0] first_dv;
        logic signed [OUT_W-1:0] cross_dvdt;
        logic signed [OUT_W-1:0] second_dv;
        logic                    overflow;
    } t_result;

    // Queue handshake toward the back end.
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_head;

endpackage

// ===== rtl/core/bpe_front.sv =====
// Front end: command acceptance, classification and a short command queue.
module bpe_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  bpe_pkg::t_item       i_item,
    output logic                 o_busy,
    output bpe_pkg::t_queue_head o_head,
    input  logic                 i_pop
);
    import bpe_pkg::*;

    t_item             r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              accept;
    logic              in_table;
    logic              push;
    logic              pop;

    // A write outside the table is taken and dropped here.
    assign o_busy   = (r_cnt == QCNT_W'(QDEPTH));
    assign accept   = i_start && !o_busy;
    assign in_table = ({1'b0, i_item.coef_index} < (IDX_W + 1)'(TABLE_SIZE));
    assign push     = accept && ((i_item.command == CMD_EVAL) || in_table);
    assign pop      = i_pop && (r_cnt != '0);

    assign o_head.valid = (r_cnt != '0);
    assign o_head.item  = r_q[r_rd];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= i_item;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/bpe_mul.sv =====
// Multi-cycle signed 64x64 multiplier built from 32x32 partial products.
module bpe_mul (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [bpe_pkg::OPND_W-1:0]   i_a,
    input  logic signed [bpe_pkg::OPND_W-1:0]   i_b,
    output logic                                o_done,
    output logic signed [bpe_pkg::PROD_W-1:0]   o_prod
);
    import bpe_pkg::*;

    logic [OPND_W-1:0]   r_ua;
    logic [OPND_W-1:0]   r_ub;
    logic                r_neg;
    logic [PROD_W-1:0]   r_acc;
    logic [2:0]          r_step;
    logic                r_busy;
    logic                r_done;
    logic [HALF_W-1:0]   a_half;
    logic [HALF_W-1:0]   b_half;
    logic [OPND_W-1:0]   part;
    logic [PROD_W-1:0]   part_sh;

    assign o_done = r_done;
    assign o_prod = $signed(r_acc);

    // One partial product per step; step bits pick the operand halves.
    assign a_half = r_step[1] ? r_ua[OPND_W-1:HALF_W] : r_ua[HALF_W-1:0];
    assign b_half = r_step[0] ? r_ub[OPND_W-1:HALF_W] : r_ub[HALF_W-1:0];
    assign part   = OPND_W'(a_half) * OPND_W'(b_half);

    always_comb begin
        unique case (r_step[1:0])
            2'd0:    part_sh = PROD_W'(part);
            2'd3:    part_sh = PROD_W'(part) << OPND_W;
            default: part_sh = PROD_W'(part) << HALF_W;
        endcase
    end

    // Operand capture and the accumulate sequence; the sign is applied last.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_ua   <= i_a[OPND_W-1] ? (~i_a + 1'b1) : i_a;
                r_ub   <= i_b[OPND_W-1] ? (~i_b + 1'b1) : i_b;
                r_neg  <= i_a[OPND_W-1] ^ i_b[OPND_W-1];
                r_acc  <= '0;
                r_step <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_step == 3'd4) begin
                    r_acc  <= r_neg ? (~r_acc + 1'b1) : r_acc;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_acc  <= r_acc + part_sh;
                    r_step <= r_step + 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/core/bpe_back.sv =====
// Back end: coefficient store, power tables and the multiply-accumulate sequencer.
module bpe_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bpe_pkg::t_queue_head       i_head,
    output logic                       o_pop,
    input  logic [bpe_pkg::ORD_W-1:0]  i_volume_order,
    input  logic [bpe_pkg::ORD_W-1:0]  i_temperature_order,
    output logic                       o_res_valid,
    output bpe_pkg::t_result           o_res
);
    import bpe_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_PV_GO   = 4'd1;
    localparam logic [3:0] S_PV_WAIT = 4'd2;
    localparam logic [3:0] S_PT_GO   = 4'd3;
    localparam logic [3:0] S_PT_WAIT = 4'd4;
    localparam logic [3:0] S_RD      = 4'd5;
    localparam logic [3:0] S_B_GO    = 4'd6;
    localparam logic [3:0] S_B_WAIT  = 4'd7;
    localparam logic [3:0] S_W_GO    = 4'd8;
    localparam logic [3:0] S_W_WAIT  = 4'd9;
    localparam logic [3:0] S_NEXT    = 4'd10;
    localparam logic [3:0] S_OUT     = 4'd11;

    localparam logic [1:0] SUM_F   = 2'd0;
    localparam logic [1:0] SUM_DV  = 2'd1;
    localparam logic [1:0] SUM_DVT = 2'd2;
    localparam logic [1:0] SUM_DV2 = 2'd3;

    logic [3:0]                r_state;
    logic [CNT_W-1:0]          r_k;
    logic [CNT_W-1:0]          r_i;
    logic [CNT_W-1:0]          r_j;
    logic [1:0]                r_s;
    logic [CNT_W-1:0]          r_vo;
    logic [CNT_W-1:0]          r_to;
    logic signed [IN_W-1:0]    r_v;
    logic signed [IN_W-1:0]    r_t;
    logic signed [OPND_W-1:0]  r_pv [MAX_VOLUME_ORDER];
    logic signed [OPND_W-1:0]  r_pt [MAX_TEMPERATURE_ORDER];
    logic [COEF_W-1:0]         r_mem [TABLE_SIZE];
    logic signed [COEF_W-1:0]  r_c;
    logic signed [OPND_W-1:0]  r_basis;
    logic signed [ACC_W-1:0]   r_acc [4];
    t_result                   r_res;
    logic                      r_res_valid;

    logic                      mem_we;
    logic [ADDR_W-1:0]         wr_addr;
    logic [ADDR_W-1:0]         rd_addr;
    logic [CNT_W-1:0]          vo_n;
    logic [CNT_W-1:0]          to_n;
    logic                      term_en;
    logic [WEIGHT_W-1:0]       weight;
    logic [CNT_W-1:0]          a_full;
    logic [CNT_W-1:0]          b_full;
    logic [VI_W-1:0]           pv_idx;
    logic [TI_W-1:0]           pt_idx;
    logic signed [COEF_W+WEIGHT_W:0] wc;
    logic                      mul_start;
    logic signed [OPND_W-1:0]  mul_a;
    logic signed [OPND_W-1:0]  mul_b;
    logic                      mul_done;
    logic signed [PROD_W-1:0]  mul_prod;
    logic signed [PROD_W-1:0]  mul_shift;
    logic [OUT_W:0]            sat_f;
    logic [OUT_W:0]            sat_dv;
    logic [OUT_W:0]            sat_dvt;
    logic [OUT_W:0]            sat_dv2;

    // Clamp a sum to the signed output range; the top bit flags saturation.
    function automatic logic [OUT_W:0] saturate(input logic signed [ACC_W-1:0] x);
        logic fits;
        fits = (x[ACC_W-1:OUT_W-1] == '0) || (x[ACC_W-1:OUT_W-1] == '1);
        if (fits) begin
            saturate = {1'b0, x[OUT_W-1:0]};
        end else if (x[ACC_W-1]) begin
            saturate = {1'b1, 1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            saturate = {1'b1, 1'b0, {(OUT_W-1){1'b1}}};
        end
    endfunction

    bpe_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    assign o_pop       = (r_state == S_IDLE) && i_head.valid;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // Coefficient writes come from the queue head while idle.
    assign mem_we  = o_pop && (i_head.item.command == CMD_WRITE);
    assign wr_addr = i_head.item.coef_index[ADDR_W-1:0];
    assign rd_addr = ADDR_W'(r_i) * ADDR_W'(MAX_TEMPERATURE_ORDER) + ADDR_W'(r_j);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= i_head.item.coef_value;
        end
        if (r_state == S_RD) begin
            r_c <= $signed(r_mem[rd_addr]);
        end
    end

    // Orders above the table size act as the table size.
    assign vo_n = (CNT_W'(i_volume_order) > CNT_W'(MAX_VOLUME_ORDER))
                  ? CNT_W'(MAX_VOLUME_ORDER) : CNT_W'(i_volume_order);
    assign to_n = (CNT_W'(i_temperature_order) > CNT_W'(MAX_TEMPERATURE_ORDER))
                  ? CNT_W'(MAX_TEMPERATURE_ORDER) : CNT_W'(i_temperature_order);

    // Weight, enable and basis powers of the sum being worked on.
    always_comb begin
        unique case (r_s)
            SUM_F: begin
                term_en = 1'b1;
                weight  = WEIGHT_W'(1);
                a_full  = r_i;
                b_full  = r_j;
            end
            SUM_DV: begin
                term_en = (r_i >= CNT_W'(1));
                weight  = WEIGHT_W'(r_i);
                a_full  = r_i - 1'b1;
                b_full  = r_j;
            end
            SUM_DVT: begin
                term_en = (r_i >= CNT_W'(1)) && (r_j >= CNT_W'(1));
                weight  = WEIGHT_W'(r_i) * WEIGHT_W'(r_j);
                a_full  = r_i - 1'b1;
                b_full  = r_j - 1'b1;
            end
            SUM_DV2: begin
                term_en = (r_i >= CNT_W'(2));
                weight  = WEIGHT_W'(r_i) * WEIGHT_W'(r_i - 1'b1);
                a_full  = r_i - CNT_W'(2);
                b_full  = r_j;
            end
            default: begin
                term_en = 1'b0;
                weight  = '0;
                a_full  = '0;
                b_full  = '0;
            end
        endcase
    end

    // One read place per power table.
    assign pv_idx = (r_state == S_PV_GO) ? VI_W'(r_k - 1'b1) : a_full[VI_W-1:0];
    assign pt_idx = (r_state == S_PT_GO) ? TI_W'(r_k - 1'b1) : b_full[TI_W-1:0];

    assign wc        = r_c * $signed({1'b0, weight});
    assign mul_shift = mul_prod >>> FRAC;

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (r_state)
            S_PV_GO: begin
                mul_start = (r_k < CNT_W'(MAX_VOLUME_ORDER));
                mul_a     = r_pv[pv_idx];
                mul_b     = OPND_W'(r_v);
            end
            S_PT_GO: begin
                mul_start = (r_k < CNT_W'(MAX_TEMPERATURE_ORDER));
                mul_a     = r_pt[pt_idx];
                mul_b     = OPND_W'(r_t);
            end
            S_B_GO: begin
                mul_start = term_en;
                mul_a     = r_pv[pv_idx];
                mul_b     = r_pt[pt_idx];
            end
            S_W_GO: begin
                mul_start = 1'b1;
                mul_a     = OPND_W'(wc);
                mul_b     = r_basis;
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    assign sat_f   = saturate(r_acc[SUM_F]);
    assign sat_dv  = saturate(r_acc[SUM_DV]);
    assign sat_dvt = saturate(r_acc[SUM_DVT]);
    assign sat_dv2 = saturate(r_acc[SUM_DV2]);

    // Payload registers of the sequencer.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (o_pop && (i_head.item.command == CMD_EVAL)) begin
                    r_v     <= i_head.item.volume;
                    r_t     <= i_head.item.temperature;
                    r_vo    <= vo_n;
                    r_to    <= to_n;
                    r_pv[0] <= OPND_W'(1) << FRAC;
                    r_pt[0] <= OPND_W'(1) << FRAC;
                    for (int n = 0; n < 4; n++) begin
                        r_acc[n] <= '0;
                    end
                end
            end
            S_PV_WAIT: begin
                if (mul_done) begin
                    r_pv[r_k[VI_W-1:0]] <= mul_shift[OPND_W-1:0];
                end
            end
            S_PT_WAIT: begin
                if (mul_done) begin
                    r_pt[r_k[TI_W-1:0]] <= mul_shift[OPND_W-1:0];
                end
            end
            S_B_WAIT: begin
                if (mul_done) begin
                    r_basis <= mul_shift[OPND_W-1:0];
                end
            end
            S_W_WAIT: begin
                if (mul_done) begin
                    r_acc[r_s] <= r_acc[r_s] + mul_shift[ACC_W-1:0];
                end
            end
            S_OUT: begin
                r_res.energy     <= sat_f[OUT_W-1:0];
                r_res.first_dv   <= sat_dv[OUT_W-1:0];
                r_res.cross_dvdt <= sat_dvt[OUT_W-1:0];
                r_res.second_dv  <= sat_dv2[OUT_W-1:0];
                r_res.overflow   <= sat_f[OUT_W] | sat_dv[OUT_W]
                                    | sat_dvt[OUT_W] | sat_dv2[OUT_W];
            end
            default: begin
            end
        endcase
    end

    // Sequencer control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_s         <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop && (i_head.item.command == CMD_EVAL)) begin
                        r_k     <= CNT_W'(1);
                        r_state <= S_PV_GO;
                    end
                end
                S_PV_GO: begin
                    if (r_k == CNT_W'(MAX_VOLUME_ORDER)) begin
                        r_k     <= CNT_W'(1);
                        r_state <= S_PT_GO;
                    end else begin
                        r_state <= S_PV_WAIT;
                    end
                end
                S_PV_WAIT: begin
                    if (mul_done) begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_PV_GO;
                    end
                end
                S_PT_GO: begin
                    if (r_k == CNT_W'(MAX_TEMPERATURE_ORDER)) begin
                        r_i <= '0;
                        r_j <= '0;
                        if ((r_vo == '0) || (r_to == '0)) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_RD;
                        end
                    end else begin
                        r_state <= S_PT_WAIT;
                    end
                end
                S_PT_WAIT: begin
                    if (mul_done) begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_PT_GO;
                    end
                end
                S_RD: begin
                    r_s     <= SUM_F;
                    r_state <= S_B_GO;
                end
                S_B_GO: begin
                    if (term_en) begin
                        r_state <= S_B_WAIT;
                    end else if (r_s == SUM_DV2) begin
                        r_state <= S_NEXT;
                    end else begin
                        r_s <= r_s + 1'b1;
                    end
                end
                S_B_WAIT: begin
                    if (mul_done) begin
                        r_state <= S_W_GO;
                    end
                end
                S_W_GO: begin
                    r_state <= S_W_WAIT;
                end
                S_W_WAIT: begin
                    if (mul_done) begin
                        if (r_s == SUM_DV2) begin
                            r_state <= S_NEXT;
                        end else begin
                            r_s     <= r_s + 1'b1;
                            r_state <= S_B_GO;
                        end
                    end
                end
                S_NEXT: begin
                    if (r_j == r_to - 1'b1) begin
                        r_j <= '0;
                        if (r_i == r_vo - 1'b1) begin
                            r_state <= S_OUT;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_RD;
                        end
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_OUT: begin
                    r_res_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/bivariate_poly_eval_with_derivs_unit.sv =====
// Polynomial surface evaluator with partial derivatives: top level.
//
// Commands enter on start/busy: a command is taken at a clock edge with start
// high and busy low. A write command stores one Q18.30 coefficient at
// coef_index and gives no result; an evaluate command returns F, dF/dV,
// d2F/dVdT and d2F/dV2 in Q34.30 with a saturation flag. Results appear for
// one cycle with o_result_strobe high; the receiver cannot hold them off.
// A two-entry command queue sits in front of the execution engine, so busy
// rises only when that queue is full.
// One shared 64x64 multiplier does every product in turn. An evaluation
// first builds the V and T power tables, then for every coefficient in use
// reads it and, for each sum it feeds, forms the basis and the weighted term;
// sums it does not feed are skipped. Orders are written on the cfg channel
// (index 0 volume, 1 temperature); the user must write them only while the
// block is idle, which the block itself does not enforce; cfg is always
// ready. Reset empties the queue, returns the engine to idle and sets both
// orders to 8; the coefficient table keeps no reset value and must be written
// before use.
module bivariate_poly_eval_with_derivs_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  i_command,
    input  logic [bpe_pkg::IDX_W-1:0]             i_coef_index,
    input  logic signed [bpe_pkg::COEF_W-1:0]     i_coef_value,
    input  logic signed [bpe_pkg::IN_W-1:0]       i_volume_in,
    input  logic signed [bpe_pkg::IN_W-1:0]       i_temperature_in,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [bpe_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [bpe_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    output logic                                  o_result_strobe,
    output logic signed [bpe_pkg::OUT_W-1:0]      o_energy_out,
    output logic signed [bpe_pkg::OUT_W-1:0]      o_first_dv_out,
    output logic signed [bpe_pkg::OUT_W-1:0]      o_cross_dvdt_out,
    output logic signed [bpe_pkg::OUT_W-1:0]      o_second_dv_out,
    output logic                                  o_overflow_flag
);
    import bpe_pkg::*;

`include "assert_macros.svh"

    logic [ORD_W-1:0] r_volume_order;
    logic [ORD_W-1:0] r_temperature_order;
    t_item            item;
    t_queue_head      head;
    logic             pop;
    t_result          res;

    // Configuration registers; writes to unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume_order      <= ORDER_RESET;
            r_temperature_order <= ORDER_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_VOLUME_ORDER) begin
                r_volume_order <= i_cfg_data[ORD_W-1:0];
            end else if (i_cfg_index == CFG_TEMPERATURE_ORDER) begin
                r_temperature_order <= i_cfg_data[ORD_W-1:0];
            end
        end
    end

    assign item.command     = i_command;
    assign item.coef_index  = i_coef_index;
    assign item.coef_value  = i_coef_value;
    assign item.volume      = i_volume_in;
    assign item.temperature = i_temperature_in;

    bpe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (item),
        .o_busy  (busy),
        .o_head  (head),
        .i_pop   (pop)
    );

    bpe_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_head              (head),
        .o_pop               (pop),
        .i_volume_order      (r_volume_order),
        .i_temperature_order (r_temperature_order),
        .o_res_valid         (o_result_strobe),
        .o_res               (res)
    );

    assign o_energy_out     = res.energy;
    assign o_first_dv_out   = res.first_dv;
    assign o_cross_dvdt_out = res.cross_dvdt;
    assign o_second_dv_out  = res.second_dv;
    assign o_overflow_flag  = res.overflow;

    // A result is shown for a single cycle, as the engine returns to idle.
    `ASSERT_CLK(a_strobe_single, i_clk, i_rst_n, o_result_strobe |=> !o_result_strobe, "result strobe held for more than one cycle")

    // The overflow flag implies that some result sits at a saturation bound.
    `ASSERT_NEVER(a_flag_bound, i_clk, i_rst_n, o_result_strobe && o_overflow_flag && !((o_energy_out == {1'b1, {(OUT_W-1){1'b0}}}) || (o_energy_out == {1'b0, {(OUT_W-1){1'b1}}}) || (o_first_dv_out == {1'b1, {(OUT_W-1){1'b0}}}) || (o_first_dv_out == {1'b0, {(OUT_W-1){1'b1}}}) || (o_cross_dvdt_out == {1'b1, {(OUT_W-1){1'b0}}}) || (o_cross_dvdt_out == {1'b0, {(OUT_W-1){1'b1}}}) || (o_second_dv_out == {1'b1, {(OUT_W-1){1'b0}}}) || (o_second_dv_out == {1'b0, {(OUT_W-1){1'b1}}})), "overflow flag without a saturated result")

endmodule
